@@ src/stack_with_running_median_macros.svh @@
// assertion macros shared by the stack with running median block
// no dependencies; taken in by `include in the files that check their logic
`ifndef STACK_WITH_RUNNING_MEDIAN_MACROS_SVH
`define STACK_WITH_RUNNING_MEDIAN_MACROS_SVH

// condition holds in the same cycle as the antecedent
`define SWRM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("swrm check failed");

// condition holds in the cycle after the antecedent
`define SWRM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("swrm check failed");

`endif

@@ src/swrm_pkg.sv @@
// shared types and constants of the stack with running median block
// no dependencies; used by the cell and the top level
package swrm_pkg;

    // field widths
    localparam int DATA_W    = 16;
    localparam int MODE_W    = 2;
    localparam int STATUS_W  = 2;

    // default number of entries and size of one median select group
    localparam int DEPTH_DEF = 256;
    localparam int MED_GROUP = 64;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_PUSH = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PEEK = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_VALID = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // control sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_MED,
        S_HOLD
    } t_state;

    // command broadcast to every sorted cell
    typedef struct packed {
        logic              ins;
        logic              rem;
        logic [DATA_W-1:0] key;
    } t_cell_ctl;

endpackage

@@ src/stack_with_running_median.sv @@
// Stack with running median. Push (tuser 0) leaves the sequencer idle and gives
// no result unless the stack is full; pop (tuser 1) waits on the registered
// read of the push order ram; peek (tuser 2) waits on the registered median
// select over the sorted chain; an empty pop or peek, or a refused push, goes
// through the hold state. Pushes are taken while an earlier result still waits
// on the output. There is no clearing pass after reset.
//
// top level: sequencer, sorted cell chain, push order ram, median select
// depends on swrm_pkg, swrm_ram, swrm_cell and the assertion macro header
`include "stack_with_running_median_macros.svh"

module stack_with_running_median #(
    parameter int DEPTH = swrm_pkg::DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [15:0] push_value
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] mode
    // result channel
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [15:0] data
    output logic [1:0]  o_m_axis_tuser    // [1:0] status
);

    localparam int DW   = swrm_pkg::DATA_W;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int AW   = $clog2(DEPTH);
    localparam int GRP  = swrm_pkg::MED_GROUP;
    localparam int NGRP = (DEPTH + GRP - 1) / GRP;

    swrm_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic             r_out_valid, n_out_valid;
    logic [1:0]       r_out_status, n_out_status;
    logic [DW-1:0]    r_out_data, n_out_data;
    logic [1:0]       r_pend_status, n_pend_status;

    swrm_pkg::t_cell_ctl cell_ctl;
    logic [DW-1:0]    cell_val [DEPTH];
    logic             cell_gt  [DEPTH];
    logic [DW-1:0]    mval     [NGRP*GRP];
    logic [DW-1:0]    r_grp    [NGRP];
    logic [DW-1:0]    med_or;
    logic [CW-1:0]    mid;

    logic          in_ready;
    logic          accept;
    logic          slot_free;
    logic          full;
    logic          empty;
    logic          ram_we;
    logic [DW-1:0] ram_rdata;

    assign full      = (r_count == CW'(DEPTH));
    assign empty     = (r_count == '0);
    assign in_ready  = (r_state == swrm_pkg::S_IDLE);
    assign accept    = i_s_axis_tvalid && in_ready;
    assign slot_free = !r_out_valid || i_m_axis_tready;
    assign ram_we    = accept && (i_s_axis_tuser == swrm_pkg::MODE_PUSH) && !full;
    assign mid       = (r_count - CW'(1)) >> 1;

    // push order store, read address always at the top entry
    swrm_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_s_axis_tdata),
        .i_raddr (AW'(r_count - CW'(1))),
        .o_rdata (ram_rdata)
    );

    // sorted chain and the per cell median mask
    for (genvar i = 0; i < NGRP * GRP; i++) begin : g_cell
        if (i < DEPTH) begin : g_real
            swrm_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (cell_ctl),
                .i_valid     (CW'(i) < r_count),
                .i_left_val  ((i == 0) ? '0 : cell_val[(i == 0) ? 0 : i - 1]),
                .i_left_gt   ((i == 0) ? 1'b0 : cell_gt[(i == 0) ? 0 : i - 1]),
                .i_right_val (cell_val[(i == DEPTH - 1) ? i : i + 1]),
                .o_val       (cell_val[i]),
                .o_gt        (cell_gt[i])
            );
            assign mval[i] = (CW'(i) == mid) ? cell_val[i] : '0;
        end else begin : g_pad
            assign mval[i] = '0;
        end
    end

    // median select first level: one masked or per group, registered
    for (genvar g = 0; g < NGRP; g++) begin : g_grp
        logic [DW-1:0] grp_or;
        always_comb begin
            grp_or = '0;
            for (int k = 0; k < GRP; k++) begin
                grp_or = grp_or | mval[g * GRP + k];
            end
        end
        always_ff @(posedge i_clk) begin
            r_grp[g] <= grp_or;
        end
    end

    // median select second level: only the selected group is nonzero
    always_comb begin
        med_or = '0;
        for (int g = 0; g < NGRP; g++) begin
            med_or = med_or | r_grp[g];
        end
    end

    // sequencer next state, chain command and result register
    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_pend_status = r_pend_status;
        n_out_valid   = r_out_valid && !i_m_axis_tready;
        n_out_status  = r_out_status;
        n_out_data    = r_out_data;
        cell_ctl.ins  = 1'b0;
        cell_ctl.rem  = 1'b0;
        cell_ctl.key  = i_s_axis_tdata;
        unique case (r_state)
            swrm_pkg::S_IDLE: begin
                if (accept) begin
                    unique case (i_s_axis_tuser)
                        swrm_pkg::MODE_PUSH: begin
                            if (full) begin
                                n_pend_status = swrm_pkg::ST_FULL;
                                n_state       = swrm_pkg::S_HOLD;
                            end else begin
                                cell_ctl.ins = 1'b1;
                                n_count      = r_count + CW'(1);
                            end
                        end
                        swrm_pkg::MODE_POP: begin
                            if (empty) begin
                                n_pend_status = swrm_pkg::ST_EMPTY;
                                n_state       = swrm_pkg::S_HOLD;
                            end else begin
                                n_state = swrm_pkg::S_POP;
                            end
                        end
                        swrm_pkg::MODE_PEEK: begin
                            if (empty) begin
                                n_pend_status = swrm_pkg::ST_EMPTY;
                                n_state       = swrm_pkg::S_HOLD;
                            end else begin
                                n_state = swrm_pkg::S_MED;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            swrm_pkg::S_POP: begin
                if (slot_free) begin
                    cell_ctl.rem = 1'b1;
                    cell_ctl.key = ram_rdata;
                    n_count      = r_count - CW'(1);
                    n_out_valid  = 1'b1;
                    n_out_status = swrm_pkg::ST_VALID;
                    n_out_data   = ram_rdata;
                    n_state      = swrm_pkg::S_IDLE;
                end
            end
            swrm_pkg::S_MED: begin
                if (slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = swrm_pkg::ST_VALID;
                    n_out_data   = med_or;
                    n_state      = swrm_pkg::S_IDLE;
                end
            end
            swrm_pkg::S_HOLD: begin
                if (slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_pend_status;
                    n_out_data   = '0;
                    n_state      = swrm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = swrm_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= swrm_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_out_status  <= n_out_status;
        r_out_data    <= n_out_data;
        r_pend_status <= n_pend_status;
    end

    assign o_s_axis_tready = in_ready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_status;

    // checks on count bookkeeping and result contents
    `SWRM_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(DEPTH))
    `SWRM_ASSERT_NEXT(a_push_count, i_clk, i_rst_n, ram_we, r_count == $past(r_count) + CW'(1))
    `SWRM_ASSERT_NEXT(a_pop_count, i_clk, i_rst_n,
        (r_state == swrm_pkg::S_POP) && slot_free,
        (r_count == $past(r_count) - CW'(1)) && r_out_valid)
    `SWRM_ASSERT_NOW(a_bad_zero, i_clk, i_rst_n,
        r_out_valid && (r_out_status != swrm_pkg::ST_VALID), r_out_data == '0)
    `SWRM_ASSERT_NOW(a_busy_nonempty, i_clk, i_rst_n,
        (r_state == swrm_pkg::S_POP) || (r_state == swrm_pkg::S_MED), !empty)

endmodule

@@ src/swrm_ram.sv @@
// generic single write port ram with one registered read port
// no dependencies; holds the push order copy of the stack
module swrm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/swrm_cell.sv @@
// one cell of the sorted chain: holds one value, shifts with its neighbors
// depends on swrm_pkg for the data width and the command struct
module swrm_cell (
    input  logic                     i_clk,
    input  swrm_pkg::t_cell_ctl      i_ctl,
    input  logic                     i_valid,
    input  logic [swrm_pkg::DATA_W-1:0] i_left_val,
    input  logic                     i_left_gt,
    input  logic [swrm_pkg::DATA_W-1:0] i_right_val,
    output logic [swrm_pkg::DATA_W-1:0] o_val,
    output logic                     o_gt
);

    logic [swrm_pkg::DATA_W-1:0] r_val;
    logic [swrm_pkg::DATA_W-1:0] n_val;
    logic                        at_or_above;

    // empty cells count as larger than any key, so insert lands after equals
    assign o_gt        = !i_valid || (r_val > i_ctl.key);
    // first cell at or above the key is the first copy of the removed value
    assign at_or_above = i_valid && (r_val >= i_ctl.key);

    // insert shifts right from the slot, remove shifts left into it
    always_comb begin
        n_val = r_val;
        if (i_ctl.ins && o_gt) begin
            n_val = i_left_gt ? i_left_val : i_ctl.key;
        end else if (i_ctl.rem && at_or_above) begin
            n_val = i_right_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;

endmodule
